@@ design/gpf_pkg.sv @@
`timescale 1ns / 1ps
package gpf_pkg;
	localparam int GRID_SIDE = 256;
	localparam int POS_W = $clog2(GRID_SIDE);
	localparam int ADDR_W = 2 * POS_W;
	localparam int DEPTH = GRID_SIDE * GRID_SIDE;

	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_READ  = 2'd1,
		CMD_STEP  = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		DIR_STILL = 2'd0,
		DIR_LOW   = 2'd1,
		DIR_HIGH  = 2'd2,
		DIR_NONE  = 2'd3
	} dir_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_STEP,
		ST_DRAIN,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic                 we;
		logic [ADDR_W-1:0]    waddr;
		logic [7:0]           wdata;
		logic [ADDR_W-1:0]    raddr;
	} mem_req_t;
endpackage

@@ design/gpf_ram.sv @@
`timescale 1ns / 1ps
module gpf_ram (
	input  logic                      clk,
	input  gpf_pkg::mem_req_t         req,
	output logic [7:0]                rdata
);
	logic [7:0] mem [gpf_pkg::DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		rdata <= mem[req.raddr];
	end
endmodule

@@ design/grid_particle_flow_step.sv @@
`timescale 1ns / 1ps
// from accept to result beat: write, still step: ST_OUT; read: ST_READ then ST_OUT
// step with flow: ST_STEP scans every line (reads run ahead of the write-back through the
// single-read-port grid memory), then ST_DRAIN and ST_OUT
// one item at a time: the next beat can be accepted the cycle after the result is taken
// reset: a clearing pass writes zeros to all GRID_SIDE*GRID_SIDE cells, no item accepted
// meanwhile; axis horizontal, cutoff 0
module grid_particle_flow_step (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] command,
	input  logic [7:0] cell_x,
	input  logic [7:0] cell_y,
	input  logic [7:0] write_height,
	input  logic [1:0] direction,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] read_height,
	output logic       step_done,
	output logic       axis_used
);
	localparam int PW = gpf_pkg::POS_W;
	localparam int AW = gpf_pkg::ADDR_W;
	localparam int CW = PW + 2;
	localparam logic [PW-1:0] LAST = PW'(gpf_pkg::GRID_SIDE - 1);

	gpf_pkg::state_t state_q, state_d;
	gpf_pkg::mem_req_t req;
	logic [7:0] rdata;
	logic [7:0] cutoff_q;
	logic axis_q;
	logic [AW-1:0] clr_q;
	logic [PW-1:0] line_q;
	logic [CW-1:0] cnt_q;
	logic high_q;
	logic vert_q;
	logic [7:0] h0_q, h1_q;
	logic g1_q;
	logic [7:0] rh_q;
	logic sd_q, au_q;
	logic ov_q;
	logic rd_ok_q;
	logic [AW-1:0] rd_addr;

	gpf_ram u_ram (.clk(clk), .req(req), .rdata(rdata));

	assign cfg_ready = 1'b1;
	assign in_ready = (state_q == gpf_pkg::ST_IDLE) && !ov_q;
	assign out_valid = ov_q;
	assign read_height = rh_q;
	assign step_done = sd_q;
	assign axis_used = au_q;

	// position in the line of the read at count c, scanned upstream to downstream
	function automatic logic [AW-1:0] addr_of(input logic [PW-1:0] ln, input logic [PW-1:0] p,
		input logic hi, input logic vt);
		logic [PW-1:0] pos;
		pos = hi ? p : LAST - p;
		return vt ? {pos, ln} : {ln, pos};
	endfunction

	logic [PW-1:0] rpos, wpos;
	logic wr_cell, last_cell, rd_live;
	logic [7:0] cur, nxt, newh;
	logic gcur;
	assign rpos = cnt_q[PW-1:0];
	assign rd_live = cnt_q < CW'(gpf_pkg::GRID_SIDE);
	// at count c: h0_q holds cell c-2, h1_q cell c-3, rdata cell c-1
	assign cur = h0_q;
	assign nxt = rdata;
	assign wpos = PW'(cnt_q - CW'(2));
	assign last_cell = (cnt_q == CW'(gpf_pkg::GRID_SIDE + 1));
	assign wr_cell = (cnt_q >= CW'(2));
	// cur gains from upstream h1 (except first cell); downstream nxt may gain from cur
	logic has_up;
	assign has_up = (wpos != '0);
	assign gcur = has_up && (cur != 8'hff) && (h1_q > cutoff_q) && (cur <= h1_q);
	logic gnxt;
	assign gnxt = !last_cell && (nxt != 8'hff) && (cur > cutoff_q) && (nxt <= cur);
	assign newh = cur + {7'd0, gcur} - {7'd0, (last_cell ? (cur != 8'd0) : gnxt)};

	always_comb begin
		state_d = state_q;
		req.we = 1'b0;
		req.waddr = '0;
		req.wdata = '0;
		rd_addr = addr_of(line_q, rpos, high_q, vert_q);
		req.raddr = rd_addr;
		case (state_q)
			gpf_pkg::ST_CLEAR: begin
				req.we = 1'b1;
				req.waddr = clr_q;
				if (clr_q == AW'(gpf_pkg::DEPTH - 1)) state_d = gpf_pkg::ST_IDLE;
			end
			gpf_pkg::ST_IDLE: begin
				req.raddr = {cell_y[PW-1:0], cell_x[PW-1:0]};
				if (in_valid && in_ready) begin
					case (gpf_pkg::cmd_t'(command))
						gpf_pkg::CMD_WRITE: begin
							req.we = 1'b1;
							req.waddr = {cell_y[PW-1:0], cell_x[PW-1:0]};
							req.wdata = write_height;
							state_d = gpf_pkg::ST_OUT;
						end
						gpf_pkg::CMD_READ: state_d = gpf_pkg::ST_READ;
						gpf_pkg::CMD_STEP: begin
							if (direction == gpf_pkg::DIR_LOW || direction == gpf_pkg::DIR_HIGH)
								state_d = gpf_pkg::ST_STEP;
							else state_d = gpf_pkg::ST_OUT;
						end
						default: state_d = gpf_pkg::ST_OUT;
					endcase
				end
			end
			gpf_pkg::ST_READ: state_d = gpf_pkg::ST_OUT;
			gpf_pkg::ST_STEP: begin
				if (wr_cell) begin
					req.we = 1'b1;
					req.waddr = addr_of(line_q, wpos, high_q, vert_q);
					req.wdata = newh;
				end
				if (last_cell && line_q == LAST) state_d = gpf_pkg::ST_DRAIN;
			end
			gpf_pkg::ST_DRAIN: state_d = gpf_pkg::ST_OUT;
			gpf_pkg::ST_OUT: state_d = gpf_pkg::ST_OUT;
			default: state_d = gpf_pkg::ST_IDLE;
		endcase
		if (state_q == gpf_pkg::ST_OUT) state_d = gpf_pkg::ST_IDLE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gpf_pkg::ST_CLEAR;
			clr_q <= '0;
			cutoff_q <= '0;
			axis_q <= 1'b0;
			ov_q <= 1'b0;
			cnt_q <= '0;
			line_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) cutoff_q <= cfg_data;
			if (state_q == gpf_pkg::ST_CLEAR) clr_q <= clr_q + AW'(1);
			if (ov_q && out_ready) ov_q <= 1'b0;
			if (state_q == gpf_pkg::ST_OUT) ov_q <= 1'b1;
			if (state_q == gpf_pkg::ST_IDLE && in_valid && in_ready) begin
				cnt_q <= '0;
				line_q <= '0;
				if (command == gpf_pkg::CMD_STEP) axis_q <= ~axis_q;
			end
			if (state_q == gpf_pkg::ST_STEP) begin
				if (last_cell) begin
					cnt_q <= '0;
					line_q <= line_q + PW'(1);
				end else begin
					cnt_q <= cnt_q + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == gpf_pkg::ST_IDLE && in_valid && in_ready) begin
			high_q <= (direction == gpf_pkg::DIR_HIGH);
			vert_q <= axis_q;
			rd_ok_q <= (command == gpf_pkg::CMD_READ);
			rh_q <= '0;
			sd_q <= (command == gpf_pkg::CMD_STEP);
			au_q <= (command == gpf_pkg::CMD_STEP) ? axis_q : 1'b0;
		end
		if (state_q == gpf_pkg::ST_READ && rd_ok_q) rh_q <= rdata;
		if (state_q == gpf_pkg::ST_STEP) begin
			if (cnt_q != '0) begin
				h1_q <= h0_q;
				h0_q <= rd_live || cnt_q == CW'(gpf_pkg::GRID_SIDE) ? rdata : 8'd0;
			end
		end
	end
endmodule

@@ test/grid_particle_flow_check.sv @@
`timescale 1ns / 1ps
module grid_particle_flow_check (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	input  logic       cfg_ready,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [1:0] command,
	input  logic [7:0] cell_x,
	input  logic [7:0] cell_y,
	input  logic [7:0] write_height,
	input  logic [1:0] direction,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic [7:0] read_height,
	input  logic       step_done,
	input  logic       axis_used,
	output int         errors,
	output int         pending
);
	typedef struct packed {
		logic [7:0] height;
		logic       done;
		logic       axis;
	} grid_reply_t;

	logic [7:0] grid [0:gpf_pkg::DEPTH-1];
	logic [7:0] cutoff;
	logic       vertical;
	grid_reply_t replies [$];

	initial begin
		for (int i = 0; i < gpf_pkg::DEPTH; i++) grid[i] = 8'd0;
		cutoff = 8'd0;
		vertical = 1'b0;
		errors = 0;
		pending = 0;
	end

	function automatic int cell_at(int line, int pos, logic vert);
		return vert ? pos * gpf_pkg::GRID_SIDE + line : line * gpf_pkg::GRID_SIDE + pos;
	endfunction

	task automatic flow_grid(logic vert, gpf_pkg::dir_t dir);
		logic [7:0] old [0:gpf_pkg::GRID_SIDE-1];
		logic       gain [0:gpf_pkg::GRID_SIDE-1];
		int up;
		int h;
		int loss;
		for (int line = 0; line < gpf_pkg::GRID_SIDE; line++) begin
			for (int i = 0; i < gpf_pkg::GRID_SIDE; i++) old[i] = grid[cell_at(line, i, vert)];
			for (int i = 0; i < gpf_pkg::GRID_SIDE; i++) begin
				gain[i] = 1'b0;
				up = (dir == gpf_pkg::DIR_HIGH) ? i - 1 : i + 1;
				if (up >= 0 && up < gpf_pkg::GRID_SIDE && old[i] != 8'd255)
					if (old[up] > cutoff && old[i] <= old[up]) gain[i] = 1'b1;
			end
			for (int i = 0; i < gpf_pkg::GRID_SIDE; i++) begin
				loss = 0;
				if (dir == gpf_pkg::DIR_HIGH) begin
					if (i + 1 < gpf_pkg::GRID_SIDE) loss = gain[i + 1];
					else if (old[i] != 8'd0) loss = 1;
				end else begin
					if (i > 0) loss = gain[i - 1];
					else if (old[i] != 8'd0) loss = 1;
				end
				h = old[i] + gain[i] - loss;
				grid[cell_at(line, i, vert)] = h[7:0];
			end
		end
	endtask

	always @(posedge clk) begin
		grid_reply_t want;
		grid_reply_t got;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) cutoff = cfg_data;
			if (out_valid && out_ready) begin
				got = '{read_height, step_done, axis_used};
				if (replies.size() == 0) begin
					errors++;
					$display("%0t: result beat with nothing expected: %p", $realtime, got);
				end else begin
					want = replies.pop_front();
					if (got !== want) begin
						errors++;
						$display("%0t: mismatch expected %p actual %p", $realtime, want, got);
					end
				end
			end
			if (in_valid && in_ready) begin
				want = '0;
				case (gpf_pkg::cmd_t'(command))
					gpf_pkg::CMD_WRITE: grid[{cell_y, cell_x}] = write_height;
					gpf_pkg::CMD_READ:  want.height = grid[{cell_y, cell_x}];
					gpf_pkg::CMD_STEP: begin
						if (gpf_pkg::dir_t'(direction) == gpf_pkg::DIR_LOW ||
							gpf_pkg::dir_t'(direction) == gpf_pkg::DIR_HIGH)
							flow_grid(vertical, gpf_pkg::dir_t'(direction));
						want.done = 1'b1;
						want.axis = vertical;
						vertical = !vertical;
					end
					default: ;
				endcase
				replies.push_back(want);
			end
			pending = replies.size();
		end
	end
endmodule

@@ test/grid_particle_flow_step_test.sv @@
`timescale 1ns / 1ps
module grid_particle_flow_step_test;
	logic       clk;
	logic       arst_n;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [7:0] cfg_data;
	logic       in_valid;
	logic       in_ready;
	logic [1:0] command;
	logic [7:0] cell_x;
	logic [7:0] cell_y;
	logic [7:0] write_height;
	logic [1:0] direction;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] read_height;
	logic       step_done;
	logic       axis_used;
	int         errors;
	int         pending;
	int         burst_left;
	int         flows_left;
	int         results_seen = 0;
	bit         long_hold_done;

	grid_particle_flow_step uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .command(command),
		.cell_x(cell_x), .cell_y(cell_y), .write_height(write_height),
		.direction(direction),
		.out_valid(out_valid), .out_ready(out_ready), .read_height(read_height),
		.step_done(step_done), .axis_used(axis_used)
	);

	grid_particle_flow_check u_check (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .command(command),
		.cell_x(cell_x), .cell_y(cell_y), .write_height(write_height),
		.direction(direction),
		.out_valid(out_valid), .out_ready(out_ready), .read_height(read_height),
		.step_done(step_done), .axis_used(axis_used),
		.errors(errors), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#8_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	always @(posedge clk)
		if (out_valid && out_ready) results_seen++;

	// receiver: random stalls, one long hold-off so the input backs up
	initial begin
		int hold;
		out_ready = 1'b0;
		long_hold_done = 1'b0;
		forever begin
			@(negedge clk);
			if (!long_hold_done && results_seen >= 30) begin
				long_hold_done = 1'b1;
				out_ready = 1'b0;
				repeat (400) @(negedge clk);
			end
			hold = $urandom_range(0, 3);
			if (hold == 0) begin
				out_ready = 1'b0;
				repeat ($urandom_range(1, 12)) @(negedge clk);
			end else begin
				out_ready = 1'b1;
				repeat ($urandom_range(1, 20)) @(negedge clk);
			end
			out_ready = 1'b1;
		end
	end

	task automatic send_beat(gpf_pkg::cmd_t c, logic [7:0] x, logic [7:0] y, logic [7:0] h,
		gpf_pkg::dir_t d);
		if (burst_left == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(0, 6)) @(negedge clk);
			burst_left = $urandom_range(1, 10);
		end
		burst_left--;
		in_valid = 1'b1;
		command = c;
		cell_x = x;
		cell_y = y;
		write_height = h;
		direction = d;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic write_cutoff(logic [7:0] value);
		while (pending != 0) @(negedge clk);
		repeat (5) @(negedge clk);
		cfg_valid = 1'b1;
		cfg_data = value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic logic [7:0] pick_pos();
		case ($urandom_range(0, 2))
			0: return 8'($urandom_range(0, 3));
			1: return 8'($urandom_range(252, 255));
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic random_beat();
		int pick;
		gpf_pkg::dir_t d;
		pick = $urandom_range(0, 99);
		d = gpf_pkg::dir_t'($urandom_range(0, 3));
		if (pick < 45)
			send_beat(gpf_pkg::CMD_WRITE, pick_pos(), pick_pos(), 8'($urandom), d);
		else if (pick < 85)
			send_beat(gpf_pkg::CMD_READ, pick_pos(), pick_pos(), 8'($urandom), d);
		else if (pick < 90)
			send_beat(gpf_pkg::CMD_NONE, 8'($urandom), 8'($urandom), 8'($urandom), d);
		else begin
			if (d == gpf_pkg::DIR_LOW || d == gpf_pkg::DIR_HIGH) begin
				if (flows_left > 0) flows_left--;
				else d = gpf_pkg::DIR_STILL;
			end
			send_beat(gpf_pkg::CMD_STEP, 8'($urandom), 8'($urandom), 8'($urandom), d);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = 8'd0;
		in_valid = 1'b0;
		command = gpf_pkg::CMD_WRITE;
		cell_x = 8'd0;
		cell_y = 8'd0;
		write_height = 8'd0;
		direction = gpf_pkg::DIR_STILL;
		burst_left = 0;
		flows_left = 4;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		write_cutoff(8'd0);
		send_beat(gpf_pkg::CMD_WRITE, 8'd0, 8'd0, 8'd255, gpf_pkg::DIR_STILL);
		send_beat(gpf_pkg::CMD_WRITE, 8'd1, 8'd0, 8'd255, gpf_pkg::DIR_NONE);
		send_beat(gpf_pkg::CMD_WRITE, 8'd2, 8'd0, 8'd255, gpf_pkg::DIR_LOW);
		send_beat(gpf_pkg::CMD_WRITE, 8'd255, 8'd0, 8'd1, gpf_pkg::DIR_HIGH);
		send_beat(gpf_pkg::CMD_WRITE, 8'd255, 8'd255, 8'd200, gpf_pkg::DIR_STILL);
		send_beat(gpf_pkg::CMD_WRITE, 8'd0, 8'd255, 8'd3, gpf_pkg::DIR_STILL);
		send_beat(gpf_pkg::CMD_WRITE, 8'd0, 8'd1, 8'd4, gpf_pkg::DIR_STILL);
		send_beat(gpf_pkg::CMD_READ, 8'd0, 8'd0, 8'd0, gpf_pkg::DIR_STILL);
		send_beat(gpf_pkg::CMD_READ, 8'd255, 8'd255, 8'hff, gpf_pkg::DIR_NONE);
		send_beat(gpf_pkg::CMD_NONE, 8'hff, 8'hff, 8'hff, gpf_pkg::DIR_NONE);
		send_beat(gpf_pkg::CMD_STEP, 8'd0, 8'd0, 8'd0, gpf_pkg::DIR_HIGH);
		send_beat(gpf_pkg::CMD_READ, 8'd1, 8'd0, 8'd0, gpf_pkg::DIR_STILL);
		send_beat(gpf_pkg::CMD_READ, 8'd255, 8'd0, 8'd0, gpf_pkg::DIR_STILL);
		send_beat(gpf_pkg::CMD_STEP, 8'd0, 8'd0, 8'd0, gpf_pkg::DIR_LOW);
		send_beat(gpf_pkg::CMD_READ, 8'd0, 8'd0, 8'd0, gpf_pkg::DIR_STILL);
		send_beat(gpf_pkg::CMD_READ, 8'd0, 8'd254, 8'd0, gpf_pkg::DIR_STILL);
		send_beat(gpf_pkg::CMD_STEP, 8'd0, 8'd0, 8'd0, gpf_pkg::DIR_STILL);
		send_beat(gpf_pkg::CMD_STEP, 8'd0, 8'd0, 8'd0, gpf_pkg::DIR_NONE);
		send_beat(gpf_pkg::CMD_READ, 8'd2, 8'd0, 8'd0, gpf_pkg::DIR_STILL);

		write_cutoff(8'd255);
		send_beat(gpf_pkg::CMD_STEP, 8'd0, 8'd0, 8'd0, gpf_pkg::DIR_HIGH);
		send_beat(gpf_pkg::CMD_READ, 8'd255, 8'd255, 8'd0, gpf_pkg::DIR_STILL);
		send_beat(gpf_pkg::CMD_READ, 8'd0, 8'd1, 8'd0, gpf_pkg::DIR_STILL);

		write_cutoff(8'd254);
		for (int i = 0; i < 30; i++) random_beat();
		send_beat(gpf_pkg::CMD_STEP, 8'd0, 8'd0, 8'd0, gpf_pkg::DIR_LOW);
		for (int i = 0; i < 10; i++) random_beat();

		write_cutoff(8'($urandom_range(0, 8)));
		for (int i = 0; i < 60; i++) random_beat();

		while (pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		if (errors == 0 && pending == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end
endmodule

@@ sim.f @@
design/gpf_pkg.sv
design/gpf_ram.sv
design/grid_particle_flow_step.sv
test/grid_particle_flow_check.sv
test/grid_particle_flow_step_test.sv
